// File: src/chaa_pkg.sv
`default_nettype none

package chaa_pkg;

    localparam int MAX_BUFFERS_DEF = 32;
    localparam int OFFSET_BITS_DEF = 24;

    localparam int CAP_W      = 24;
    localparam int FIELD_W    = 24;
    localparam int HANDLE_W   = 32;
    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 112;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_LOOK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OOM        = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        EM_MOVE,
        EM_ALLOC,
        EM_FREE,
        EM_LOOK,
        EM_ERR
    } t_emit;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_COMP_RD,
        S_COMP_EV,
        S_COMP_END,
        S_ALLOC_FIN,
        S_SRCH_RD,
        S_SRCH_EV,
        S_HIT_ANS,
        S_MISS_ANS
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    srch_init;
        logic    srch_dec;
        logic    comp_init;
        logic    comp_do;
        logic    comp_inc;
        logic    comp_end;
        logic    alloc_do;
        logic    free_do;
        logic    emit;
        t_emit   emit_sel;
        t_status err_code;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic is_alloc;
        logic is_free;
        logic is_look;
        logic need_comp;
        logic full;
        logic nofit;
        logic slots_zero;
        logic hit;
        logic idx_zero;
        logic comp_valid;
        logic comp_move;
        logic comp_last;
    } t_stat;

endpackage

`default_nettype wire

// File: src/compacting_handle_allocator_unit.sv
// Free and look up scan the entries newest first until a hit or the oldest entry, then
// answer; an allocate that fits answers without a table walk.
// An allocate that must compact walks the table once, waiting while the output stalls
// before each move, then answers.
// One item is in work at a time; the controller takes a new item only in its idle state.
// Synchronous active-low reset empties the table and clears capacity, top and handle counter.
`default_nettype none

module compacting_handle_allocator_unit #(
    parameter int MAX_BUFFERS = chaa_pkg::MAX_BUFFERS_DEF,
    parameter int OFFSET_BITS = chaa_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [chaa_pkg::CAP_W-1:0]     i_cfg_data,   // heap_capacity
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [chaa_pkg::IN_USER_W-1:0] i_s_tuser,    // action
    input  wire logic [chaa_pkg::IN_DATA_W-1:0] i_s_tdata,    // alloc_size, zero_fill, handle_in
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic                                o_m_tuser,    // kind
    // status, handle_out, address_out, move_source, move_length, fill_request
    output logic [chaa_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast
);
    import chaa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    chaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    chaa_dp #(
        .MAX_BUFFERS (MAX_BUFFERS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tuser   (o_m_tuser),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

// File: src/chaa_ctrl.sv
`default_nettype none

module chaa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire chaa_pkg::t_stat i_stat,
    output chaa_pkg::t_cmd     o_cmd
);
    import chaa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.emit_sel = EM_ERR;
        o_cmd.err_code = ST_OK;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_alloc) begin
                    if (i_stat.need_comp) begin
                        o_cmd.comp_init = 1'b1;
                        n_state = i_stat.slots_zero ? S_COMP_END : S_COMP_RD;
                    end else begin
                        n_state = S_ALLOC_FIN;
                    end
                end else if ((i_stat.is_free || i_stat.is_look) && !i_stat.slots_zero) begin
                    o_cmd.srch_init = 1'b1;
                    n_state = S_SRCH_RD;
                end else begin
                    n_state = S_MISS_ANS;
                end
            end
            S_COMP_RD: n_state = S_COMP_EV;
            S_COMP_EV: begin
                if (!(i_stat.comp_valid && i_stat.comp_move && !i_stat.out_free)) begin
                    if (i_stat.comp_valid) begin
                        o_cmd.comp_do = 1'b1;
                        if (i_stat.comp_move) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = EM_MOVE;
                        end
                    end
                    if (i_stat.comp_last) begin
                        n_state = S_COMP_END;
                    end else begin
                        o_cmd.comp_inc = 1'b1;
                        n_state = S_COMP_RD;
                    end
                end
            end
            S_COMP_END: begin
                o_cmd.comp_end = 1'b1;
                n_state = S_ALLOC_FIN;
            end
            S_ALLOC_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.err_code = ST_TABLE_FULL;
                    end else if (i_stat.nofit) begin
                        o_cmd.err_code = ST_OOM;
                    end else begin
                        o_cmd.alloc_do = 1'b1;
                        o_cmd.emit_sel = EM_ALLOC;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SRCH_RD: n_state = S_SRCH_EV;
            S_SRCH_EV: begin
                if (i_stat.hit) begin
                    n_state = S_HIT_ANS;
                end else if (i_stat.idx_zero) begin
                    n_state = S_MISS_ANS;
                end else begin
                    o_cmd.srch_dec = 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_HIT_ANS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.is_free) begin
                        o_cmd.free_do  = 1'b1;
                        o_cmd.emit_sel = EM_FREE;
                    end else begin
                        o_cmd.emit_sel = EM_LOOK;
                    end
                    n_state = S_IDLE;
                end
            end
            S_MISS_ANS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.err_code = ST_NOT_FOUND;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/chaa_dp.sv
`default_nettype none

module chaa_dp #(
    parameter int MAX_BUFFERS = chaa_pkg::MAX_BUFFERS_DEF,
    parameter int OFFSET_BITS = chaa_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [chaa_pkg::IN_USER_W-1:0]      i_s_tuser,
    input  wire logic [chaa_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  wire logic                                i_cfg_valid,
    input  wire logic [chaa_pkg::CAP_W-1:0]          i_cfg_data,
    input  wire logic                                i_m_tready,
    output logic                                     o_m_tvalid,
    output logic                                     o_m_tuser,
    output logic [chaa_pkg::OUT_DATA_W-1:0]          o_m_tdata,
    output logic                                     o_m_tlast,
    input  wire chaa_pkg::t_cmd                      i_cmd,
    output chaa_pkg::t_stat                          o_stat
);
    import chaa_pkg::*;

    localparam int IW = $clog2(MAX_BUFFERS);
    localparam int CW = $clog2(MAX_BUFFERS + 1);
    localparam int OB = OFFSET_BITS;
    localparam int SW = (OB > FIELD_W) ? OB : FIELD_W;

    // table memories, one write and one registered read per cycle
    logic [HANDLE_W-1:0] m_handle [MAX_BUFFERS];
    logic [OB-1:0]       m_offset [MAX_BUFFERS];
    logic [OB-1:0]       m_size   [MAX_BUFFERS];

    logic [MAX_BUFFERS-1:0] r_valid;
    logic [CW-1:0]          r_slots;
    logic [OB-1:0]          r_top;
    logic [HANDLE_W-1:0]    r_next_handle;
    logic [CAP_W-1:0]       r_cap;

    t_action             r_action;
    logic [OB-1:0]       r_size;
    logic                r_fill;
    logic [HANDLE_W-1:0] r_handle_in;

    logic [IW-1:0]       r_idx;
    logic [CW-1:0]       r_w;
    logic [OB-1:0]       r_ctop;

    logic [HANDLE_W-1:0] r_rd_handle;
    logic [OB-1:0]       r_rd_offset;
    logic [OB-1:0]       r_rd_size;

    logic                r_out_valid;
    logic                r_out_kind;
    logic                r_out_last;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                we;
    logic [IW-1:0]       wa;
    logic [HANDLE_W-1:0] wd_handle;
    logic [OB-1:0]       wd_offset;
    logic [OB-1:0]       wd_size;
    logic                comp_move;
    logic [SW:0]         fit_sum;
    logic                full;
    logic                nofit;
    logic [SW-1:0]       ext_a;
    logic [SW-1:0]       ext_s;
    logic [SW-1:0]       ext_l;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic                n_out_kind;

    assign comp_move = r_rd_offset > r_ctop;
    assign full      = r_slots == CW'(MAX_BUFFERS);
    assign fit_sum   = (SW+1)'(r_top) + (SW+1)'(r_size);
    assign nofit     = fit_sum > (SW+1)'(r_cap);

    always_comb begin
        o_stat            = '0;
        o_stat.out_free   = !r_out_valid || i_m_tready;
        o_stat.is_alloc   = r_action == ACT_ALLOC;
        o_stat.is_free    = r_action == ACT_FREE;
        o_stat.is_look    = r_action == ACT_LOOK;
        o_stat.full       = full;
        o_stat.nofit      = nofit;
        o_stat.need_comp  = full || nofit;
        o_stat.slots_zero = r_slots == '0;
        o_stat.hit        = r_valid[r_idx] && (r_rd_handle == r_handle_in);
        o_stat.idx_zero   = r_idx == '0;
        o_stat.comp_valid = r_valid[r_idx];
        o_stat.comp_move  = comp_move;
        o_stat.comp_last  = (CW'(r_idx) + CW'(1)) == r_slots;
    end

    // write port: compaction writes at the fill index, an allocate appends
    always_comb begin
        we        = i_cmd.comp_do || i_cmd.alloc_do;
        if (i_cmd.comp_do) begin
            wa        = r_w[IW-1:0];
            wd_handle = r_rd_handle;
            wd_offset = comp_move ? r_ctop : r_rd_offset;
            wd_size   = r_rd_size;
        end else begin
            wa        = r_slots[IW-1:0];
            wd_handle = r_next_handle;
            wd_offset = r_top;
            wd_size   = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            m_handle[wa] <= wd_handle;
            m_offset[wa] <= wd_offset;
            m_size[wa]   <= wd_size;
        end
        r_rd_handle <= m_handle[r_idx];
        r_rd_offset <= m_offset[r_idx];
        r_rd_size   <= m_size[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_slots       <= '0;
            r_top         <= '0;
            r_next_handle <= '0;
            r_cap         <= '0;
            r_action      <= ACT_NONE;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.load_in) begin
                r_action <= t_action'(i_s_tuser);
            end
            if (i_cmd.comp_do) begin
                r_valid[r_w[IW-1:0]] <= 1'b1;
            end
            if (i_cmd.free_do) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (i_cmd.comp_end) begin
                for (int j = 0; j < MAX_BUFFERS; j++) begin
                    if (CW'(j) >= r_w) begin
                        r_valid[j] <= 1'b0;
                    end
                end
                r_slots <= r_w;
                r_top   <= r_ctop;
            end
            if (i_cmd.alloc_do) begin
                r_valid[r_slots[IW-1:0]] <= 1'b1;
                r_slots       <= r_slots + CW'(1);
                r_next_handle <= r_next_handle + HANDLE_W'(1);
                r_top         <= r_top + r_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_size      <= OB'(SW'(i_s_tdata[FIELD_W-1:0]));
            r_fill      <= i_s_tdata[FIELD_W];
            r_handle_in <= i_s_tdata[FIELD_W+HANDLE_W:FIELD_W+1];
        end
        if (i_cmd.srch_init) begin
            r_idx <= IW'(r_slots - CW'(1));
        end else if (i_cmd.srch_dec) begin
            r_idx <= r_idx - IW'(1);
        end else if (i_cmd.comp_init) begin
            r_idx <= '0;
        end else if (i_cmd.comp_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.comp_init) begin
            r_w    <= '0;
            r_ctop <= '0;
        end else if (i_cmd.comp_do) begin
            r_w    <= r_w + CW'(1);
            r_ctop <= r_ctop + r_rd_size;
        end
    end

    // result packing: status, handle, address, source, length, fill
    always_comb begin
        n_out_data = '0;
        n_out_kind = 1'b1;
        ext_a = '0;
        ext_s = '0;
        ext_l = '0;
        case (i_cmd.emit_sel)
            EM_MOVE: begin
                n_out_kind = 1'b0;
                ext_a = SW'(r_ctop);
                ext_s = SW'(r_rd_offset);
                ext_l = SW'(r_rd_size);
            end
            EM_ALLOC: begin
                ext_a = SW'(r_top);
                ext_l = SW'(r_size);
                n_out_data[33:2] = r_next_handle;
                n_out_data[106]  = r_fill;
            end
            EM_LOOK: begin
                ext_a = SW'(r_rd_offset);
            end
            EM_ERR: begin
                n_out_data[1:0] = i_cmd.err_code;
            end
            default: ;
        endcase
        n_out_data[57:34]  = ext_a[FIELD_W-1:0];
        n_out_data[81:58]  = ext_s[FIELD_W-1:0];
        n_out_data[105:82] = ext_l[FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= n_out_data;
            r_out_kind <= n_out_kind;
            r_out_last <= n_out_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: src/chaa_chk.sv
`default_nettype none

module chaa_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_s_tready,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic                            o_m_tuser,
    input wire logic [chaa_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                            o_m_tlast
);

    // move commands never close an item, answers always do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == o_m_tlast))
        else $error("tlast does not match result kind");

    a_move_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[1:0] == 2'd0))
        else $error("move item with nonzero status");

    a_err_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast && (o_m_tdata[1:0] != 2'd0)) |-> (o_m_tdata[33:2] == '0))
        else $error("error answer carries a handle");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("new item taken while moves are pending");

endmodule

bind compacting_handle_allocator_unit chaa_chk u_chaa_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tuser  (o_m_tuser),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
